>>> rtl/gha_pkg.sv
// shared types and constants of the generational handle allocator
`timescale 1ns / 1ps
package gha_pkg;

  // fixed field widths of the channels
  localparam int unsigned ID_W  = 10;
  localparam int unsigned GEN_W = 16;

  // parameter defaults
  localparam int unsigned MAX_HANDLES_DEF = 1024;
  localparam int unsigned GEN_BITS_DEF    = 16;

  // operation codes on the input channel
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  // decoded command
  typedef enum logic [1:0] {
    CMD_CREATE,
    CMD_DESTROY,
    CMD_QUERY,
    CMD_NOP
  } cmd_t;

  // one classified item as it sits in the queue
  typedef struct packed {
    cmd_t             cmd;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
    logic             hvalid;
  } gha_item_t;

endpackage

>>> rtl/gha_if.sv
// channel interfaces of the generational handle allocator
`timescale 1ns / 1ps
interface gha_in_if import gha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [ID_W-1:0]  handle_id;
  logic [GEN_W-1:0] handle_generation;
  logic             handle_valid;

  modport source (output valid, op, handle_id, handle_generation, handle_valid,
                  input ready);
  modport sink (input valid, op, handle_id, handle_generation, handle_valid,
                output ready);
endinterface

interface gha_out_if import gha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  new_id;
  logic [GEN_W-1:0] new_generation;
  logic             alive;
  logic [1:0]       status;

  modport source (output valid, new_id, new_generation, alive, status,
                  input ready);
  modport sink (input valid, new_id, new_generation, alive, status,
                output ready);
endinterface

>>> rtl/gha_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module gha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/gha_front.sv
// front end: accepts input beats, decodes the operation, two-entry queue
`timescale 1ns / 1ps
module gha_front import gha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gha_in_if.sink    in_bus,
  output logic      q_valid,
  input  logic      q_pop,
  output gha_item_t q_item
);

  gha_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  gha_item_t  dec_item;

  // decode the incoming beat
  always_comb begin
    dec_item.id     = in_bus.handle_id;
    dec_item.gen    = in_bus.handle_generation;
    dec_item.hvalid = in_bus.handle_valid;
    case (in_bus.op)
      OP_CREATE:  dec_item.cmd = CMD_CREATE;
      OP_DESTROY: dec_item.cmd = CMD_DESTROY;
      OP_QUERY:   dec_item.cmd = CMD_QUERY;
      default:    dec_item.cmd = CMD_NOP;
    endcase
  end

  assign in_bus.ready = (cnt_r != 2'd2);
  assign push         = in_bus.valid && in_bus.ready;
  assign q_valid      = (cnt_r != 2'd0);
  assign q_item       = slot_r[rd_ptr_r];

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule

>>> rtl/gha_back.sv
// back end: executes create, destroy and query against the id store
`timescale 1ns / 1ps
module gha_back import gha_pkg::*; #(
  parameter int unsigned MAX_HANDLES = MAX_HANDLES_DEF,
  parameter int unsigned GEN_BITS    = GEN_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  gha_item_t q_item,
  gha_out_if.source out_bus
);

  localparam int unsigned IDW = $clog2(MAX_HANDLES);
  localparam int unsigned CW  = $clog2(MAX_HANDLES + 1);
  localparam int unsigned EW  = GEN_BITS + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_STACK, ST_ENTRY, ST_CHECK} state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [IDW-1:0]   id_r, id_nxt;
  logic [GEN_W-1:0] hgen_r, hgen_nxt;
  logic [CW-1:0]    free_cnt_r, free_cnt_nxt;
  logic [CW-1:0]    fresh_cnt_r, fresh_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [GEN_W-1:0] out_gen_r, out_gen_nxt;
  logic             out_alive_r, out_alive_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_load;

  // entry store: {free mark, generation}; free stack of ids
  logic           ent_we, ent_re;
  logic [IDW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0]  ent_wdata, ent_rdata;
  logic           stk_we, stk_re;
  logic [IDW-1:0] stk_waddr, stk_raddr, stk_rdata;

  gha_ram #(.WIDTH(EW), .DEPTH(MAX_HANDLES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  gha_ram #(.WIDTH(IDW), .DEPTH(MAX_HANDLES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (id_r),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // width adaptation between fixed fields and parameterized state
  logic [ID_W+CW-1:0]       hid_wide, fresh_wide;
  logic [IDW+ID_W-1:0]      slot_wide;
  logic [GEN_BITS+GEN_W-1:0] sgen_wide, hgen_wide;
  logic [CW-1:0]            free_dec;
  logic                     slot_free, in_range, gen_match, was_alive;

  assign hid_wide   = {{CW{1'b0}}, q_item.id};
  assign fresh_wide = {{ID_W{1'b0}}, fresh_cnt_r};
  assign slot_wide  = {{ID_W{1'b0}}, id_r};
  assign sgen_wide  = {{GEN_W{1'b0}}, ent_rdata[GEN_BITS-1:0]};
  assign hgen_wide  = {{GEN_BITS{1'b0}}, hgen_r};
  assign free_dec   = free_cnt_r - CW'(1);
  assign slot_free  = !out_valid_r || out_bus.ready;
  assign in_range   = hid_wide < fresh_wide;
  assign gen_match  = (sgen_wide == hgen_wide);
  assign was_alive  = gen_match && !ent_rdata[GEN_BITS];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    hgen_nxt       = hgen_r;
    free_cnt_nxt   = free_cnt_r;
    fresh_cnt_nxt  = fresh_cnt_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_id_nxt     = out_id_r;
    out_gen_nxt    = out_gen_r;
    out_alive_nxt  = out_alive_r;
    out_status_nxt = out_status_r;
    out_load       = 1'b0;
    q_pop          = 1'b0;
    ent_we         = 1'b0;
    ent_waddr      = id_r;
    ent_wdata      = '0;
    ent_re         = 1'b0;
    ent_raddr      = id_r;
    stk_we         = 1'b0;
    stk_waddr      = free_cnt_r[IDW-1:0];
    stk_re         = 1'b0;
    stk_raddr      = free_dec[IDW-1:0];

    case (state_r)
      ST_IDLE: begin
        // start only when the result register will be free at the end
        if (q_valid && slot_free) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_item.cmd;
          id_nxt         = hid_wide[IDW-1:0];
          hgen_nxt       = q_item.gen;
          out_id_nxt     = '0;
          out_gen_nxt    = '0;
          out_alive_nxt  = 1'b0;
          out_status_nxt = STAT_OK;
          case (q_item.cmd)
            CMD_CREATE: begin
              if (free_cnt_r != '0) begin
                // reuse the most recently freed id
                free_cnt_nxt = free_dec;
                stk_re       = 1'b1;
                state_nxt    = ST_STACK;
              end else if (fresh_cnt_r < CW'(MAX_HANDLES)) begin
                // fresh id at generation zero
                ent_we        = 1'b1;
                ent_waddr     = fresh_cnt_r[IDW-1:0];
                ent_wdata     = '0;
                fresh_cnt_nxt = fresh_cnt_r + CW'(1);
                out_id_nxt    = fresh_wide[ID_W-1:0];
                out_load      = 1'b1;
              end else begin
                out_status_nxt = STAT_FULL;
                out_load       = 1'b1;
              end
            end
            CMD_DESTROY, CMD_QUERY: begin
              if (q_item.hvalid && in_range) begin
                ent_re    = 1'b1;
                ent_raddr = hid_wide[IDW-1:0];
                state_nxt = ST_CHECK;
              end else begin
                if (q_item.cmd == CMD_DESTROY) begin
                  out_status_nxt = STAT_IGNORED;
                end
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_STACK: begin
        // popped id known, fetch its entry
        id_nxt    = stk_rdata;
        ent_re    = 1'b1;
        ent_raddr = stk_rdata;
        state_nxt = ST_ENTRY;
      end
      ST_ENTRY: begin
        // clear the free mark, keep the generation
        ent_we      = 1'b1;
        ent_wdata   = {1'b0, ent_rdata[GEN_BITS-1:0]};
        out_id_nxt  = slot_wide[ID_W-1:0];
        out_gen_nxt = sgen_wide[GEN_W-1:0];
        out_load    = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_CHECK: begin
        out_load  = 1'b1;
        state_nxt = ST_IDLE;
        if (cmd_r == CMD_DESTROY) begin
          if (was_alive && (free_cnt_r < CW'(MAX_HANDLES))) begin
            // mark free, bump generation, push on the stack
            ent_we        = 1'b1;
            ent_wdata     = {1'b1, ent_rdata[GEN_BITS-1:0] + GEN_BITS'(1)};
            stk_we        = 1'b1;
            free_cnt_nxt  = free_cnt_r + CW'(1);
            out_alive_nxt = 1'b1;
          end else begin
            out_status_nxt = STAT_IGNORED;
          end
        end else begin
          out_alive_nxt = was_alive;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_cnt_r  <= '0;
      fresh_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fresh_cnt_r <= fresh_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    hgen_r       <= hgen_nxt;
    out_id_r     <= out_id_nxt;
    out_gen_r    <= out_gen_nxt;
    out_alive_r  <= out_alive_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.new_id         = out_id_r;
  assign out_bus.new_generation = out_gen_r;
  assign out_bus.alive          = out_alive_r;
  assign out_bus.status         = out_status_r;

  // every freed id was once a fresh id
  a_free_le_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= fresh_cnt_r)
    else $error("free stack deeper than allocated ids");

  // fresh count never passes the store size
  a_fresh_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_cnt_r <= CW'(MAX_HANDLES))
    else $error("fresh count beyond store size");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_bus.ready))
    else $error("result register overwritten");

  // create with an empty stack either grows the fresh count or reports full
  a_create_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && q_pop && q_item.cmd == CMD_CREATE && free_cnt_r == '0)
    |=> (fresh_cnt_r == $past(fresh_cnt_r) + CW'(1)) || (out_status_r == STAT_FULL))
    else $error("create from empty stack lost");

endmodule

>>> rtl/generational_handle_allocator.sv
// Generational handle allocator: create, destroy and query id/generation handles.
// Input channel in_bus carries one operation per beat (op, handle_id,
// handle_generation, handle_valid); result channel out_bus returns exactly one
// beat per operation, in order (new_id, new_generation, alive, status).
// Both channels use valid/ready; a beat moves when both are high.
// Accepted beats enter a two-entry queue; the executing end takes one at a
// time and works against two memories, the entry store {free mark, generation}
// and the free stack, each with one registered read.
// Steps per operation in the executing end: create from the free stack does a
// stack read, then an entry read, then the write back; destroy or query of a
// valid in-range handle does an entry read, then the check and write; fresh
// create, store full, out-of-range or invalid handle and unused op are answered
// straight from the idle state.
// Reset empties the queue and the result register and clears both counters;
// memories need no clearing, entries are only read below the fresh count.
// A stalled receiver holds the result register; the queue keeps taking beats
// until it is full, then in_bus.ready drops.
`timescale 1ns / 1ps
module generational_handle_allocator import gha_pkg::*; #(
  parameter int unsigned MAX_HANDLES = MAX_HANDLES_DEF,
  parameter int unsigned GEN_BITS    = GEN_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gha_in_if.sink    in_bus,
  gha_out_if.source out_bus
);

  logic      q_valid;
  logic      q_pop;
  gha_item_t q_item;

  // accept and classify
  gha_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  // execute against the id store
  gha_back #(
    .MAX_HANDLES (MAX_HANDLES),
    .GEN_BITS    (GEN_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .out_bus (out_bus)
  );

endmodule
